/* rtl/assert_macros.svh */
// Assertion macros shared by the clip LFO track RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Plain property check, disabled while reset is held.
`define CLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same-cycle implication check, disabled while reset is held.
`define CLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CLT_ASSERT(lbl, clk, rst_n, prop, msg)
`define CLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/clt_pkg.sv */
// Shared types, codes and the sine table entry rounding for the clip LFO track.
`timescale 1ns / 1ps

package clt_pkg;

    // Q30 value of pi used to build the quarter-wave table
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_SAW      = 2'd3
    } t_wave_kind;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_RESTART = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        CFG_WAVE_KIND    = 3'd0,
        CFG_FREQUENCY    = 3'd1,
        CFG_PHASE_OFFSET = 3'd2,
        CFG_AMPLITUDE    = 3'd3,
        CFG_BIAS         = 3'd4,
        CFG_SPEED        = 3'd5,
        CFG_WEIGHT       = 3'd6,
        CFG_DURATION     = 3'd7
    } t_cfg_idx;

    // Configuration register file contents
    typedef struct packed {
        t_wave_kind  wave_kind;
        logic [15:0] frequency;
        logic [15:0] phase_offset;
        logic [15:0] amplitude;
        logic [15:0] bias;
        logic [15:0] speed;
        logic [15:0] weight;
        logic [31:0] duration;
    } t_cfg;

    // Datapath commands, at most one step per cycle
    typedef struct packed {
        logic load_in;
        logic mul_step;
        logic advance;
        logic phase;
        logic lookup;
        logic track;
        logic load_out;
    } t_cmd;

    // One quarter-wave entry from its Q30 Taylor sum: negative sums clamp
    // to zero, then rounded to Q15 and clamped to 16 bits unsigned.
    function automatic logic [15:0] clt_sine_round(input logic signed [63:0] sum_q30);
        logic signed [63:0] sum;
        sum = sum_q30;
        if (sum < 0) begin
            sum = '0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd65535) begin
            sum = 64'sd65535;
        end
        return sum[15:0];
    endfunction

endpackage

/* rtl/clt_cfg_regs.sv */
// Configuration register file of the clip LFO track.
`timescale 1ns / 1ps

module clt_cfg_regs
    import clt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // Register writes, one per cycle, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_kind    <= WAVE_SINE;
            r_cfg.frequency    <= 16'd256;
            r_cfg.phase_offset <= 16'd0;
            r_cfg.amplitude    <= 16'd256;
            r_cfg.bias         <= 16'd0;
            r_cfg.speed        <= 16'd256;
            r_cfg.weight       <= 16'd256;
            r_cfg.duration     <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WAVE_KIND:    r_cfg.wave_kind    <= t_wave_kind'(i_cfg_data[1:0]);
                CFG_FREQUENCY:    r_cfg.frequency    <= i_cfg_data[15:0];
                CFG_PHASE_OFFSET: r_cfg.phase_offset <= i_cfg_data[15:0];
                CFG_AMPLITUDE:    r_cfg.amplitude    <= i_cfg_data[15:0];
                CFG_BIAS:         r_cfg.bias         <= i_cfg_data[15:0];
                CFG_SPEED:        r_cfg.speed        <= i_cfg_data[15:0];
                CFG_WEIGHT:       r_cfg.weight       <= i_cfg_data[15:0];
                CFG_DURATION:     r_cfg.duration     <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/clt_ctrl.sv */
// Sequencing controller: input/output handshakes and datapath step commands.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clt_ctrl
    import clt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADV,
        S_PHASE,
        S_LOOK,
        S_TRACK,
        S_SCALE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_slot_free;

    // Output slot can take a result when empty or being drained
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Next state and step commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state        = S_ADV;
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = S_PHASE;
            end
            S_PHASE: begin
                o_cmd.phase = 1'b1;
                n_state     = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_TRACK;
            end
            S_TRACK: begin
                o_cmd.track = 1'b1;
                n_state     = S_SCALE;
            end
            S_SCALE: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and output-valid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `CLT_ASSERT(a_cmd_onehot0, i_clk, i_rst_n, $onehot0(o_cmd), "two datapath steps at once")
    `CLT_ASSERT(a_accept_starts, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> o_cmd.mul_step,
        "accepted transaction did not start the datapath")
    `CLT_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, !o_cmd.load_out,
        "pending result overwritten")

endmodule

/* rtl/clt_datapath.sv */
// Datapath: clip time advance, phase, wave table lookup and output scaling.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clt_datapath
    import clt_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    input  logic        i_op,
    input  logic [23:0] i_time_step,
    output logic [31:0] o_value,
    output logic        o_playing,
    output logic        o_finished
);

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int RAW_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = 14 + RAW_W;

    // Registers of the item in flight and the clip state
    t_op                r_op;
    logic [23:0]        r_step;
    logic [31:0]        r_delta;
    logic [31:0]        r_time, n_time;
    logic               r_playing, n_playing;
    logic               r_done, n_done;
    logic [15:0]        r_phase;
    logic [15:0]        r_sine;
    logic signed [34:0] r_track;
    logic [31:0]        r_out_value;
    logic               r_out_playing;
    logic               r_out_finished;

    // Quarter-wave sine table, built at elaboration
    logic [15:0] w_rom [SINE_TABLE_DEPTH];
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] AngleQ30 =
            (PI_Q30 * 64'(2 * k + 1)) / 64'(4 * SINE_TABLE_DEPTH);
        // Taylor terms x^(2n+1)/(2n+1)!, each built from the one before
        localparam logic [63:0] Term1 =
            ((((AngleQ30 * AngleQ30) >> 30) * AngleQ30) >> 30) / 64'd6;
        localparam logic [63:0] Term2 =
            ((((Term1 * AngleQ30) >> 30) * AngleQ30) >> 30) / 64'd20;
        localparam logic [63:0] Term3 =
            ((((Term2 * AngleQ30) >> 30) * AngleQ30) >> 30) / 64'd42;
        localparam logic [63:0] Term4 =
            ((((Term3 * AngleQ30) >> 30) * AngleQ30) >> 30) / 64'd72;
        localparam logic [63:0] Term5 =
            ((((Term4 * AngleQ30) >> 30) * AngleQ30) >> 30) / 64'd110;
        localparam logic [63:0] Term6 =
            ((((Term5 * AngleQ30) >> 30) * AngleQ30) >> 30) / 64'd156;
        localparam logic [63:0] Term7 =
            ((((Term6 * AngleQ30) >> 30) * AngleQ30) >> 30) / 64'd210;
        localparam logic signed [63:0] SumQ30 =
            signed'(AngleQ30) - signed'(Term1) + signed'(Term2) - signed'(Term3)
            + signed'(Term4) - signed'(Term5) + signed'(Term6) - signed'(Term7);
        localparam logic [15:0] Entry = clt_sine_round(SumQ30);
        assign w_rom[k] = Entry;
    end

    // Step times speed, floor to Q16.16
    logic signed [39:0] w_step_prod;
    assign w_step_prod = $signed(r_step) * $signed(i_cfg.speed);

    // Saturating time advance and one-shot end check
    logic [32:0] w_sum;
    logic [31:0] w_sat;
    logic        w_step_pos;
    logic        w_reach;

    assign w_sum      = {r_time[31], r_time} + {r_delta[31], r_delta};
    assign w_step_pos = !r_step[23] && (r_step != '0);

    always_comb begin
        if (w_sum[32] != w_sum[31]) begin
            w_sat = w_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    assign w_reach = (i_cfg.duration != '0) && !w_sat[31] && (w_sat >= i_cfg.duration);

    always_comb begin
        n_time    = r_time;
        n_playing = r_playing;
        n_done    = 1'b0;
        if (r_op == OP_RESTART) begin
            n_time    = '0;
            n_playing = 1'b1;
        end else if (w_step_pos && r_playing) begin
            if (w_reach) begin
                n_time    = i_cfg.duration;
                n_playing = 1'b0;
                n_done    = 1'b1;
            end else begin
                n_time = w_sat;
            end
        end
    end

    // Phase: only the low 24 bits of time times frequency reach bits 23..8
    logic [39:0] w_tprod;
    assign w_tprod = 40'(r_time[23:0]) * 40'(i_cfg.frequency);

    // Table index from the position inside the quadrant, mirrored in odd quadrants
    logic [PROD_W-1:0] w_iprod;
    logic [RAW_W-1:0]  w_iraw;
    logic [IDX_W-1:0]  w_idx_q;
    logic [IDX_W-1:0]  w_idx;

    assign w_iprod = PROD_W'(r_phase[13:0]) * PROD_W'(SINE_TABLE_DEPTH);
    assign w_iraw  = w_iprod[PROD_W-1:14];

    always_comb begin
        if (w_iraw >= RAW_W'(SINE_TABLE_DEPTH)) begin
            w_idx_q = IDX_W'(SINE_TABLE_DEPTH - 1);
        end else begin
            w_idx_q = w_iraw[IDX_W-1:0];
        end
        w_idx = r_phase[14] ? (IDX_W'(SINE_TABLE_DEPTH - 1) - w_idx_q) : w_idx_q;
    end

    // Wave value in Q1.15, full scale +-32768
    logic signed [17:0] w_wave;
    always_comb begin
        case (i_cfg.wave_kind)
            WAVE_TRIANGLE: begin
                if (!r_phase[15]) begin
                    w_wave = $signed({1'b0, r_phase, 1'b0}) - 18'sd32768;
                end else begin
                    w_wave = 18'sd98304 - $signed({1'b0, r_phase, 1'b0});
                end
            end
            WAVE_SQUARE: w_wave = r_phase[15] ? -18'sd32768 : 18'sd32768;
            WAVE_SAW:    w_wave = $signed({2'b00, r_phase}) - 18'sd32768;
            default: begin
                if (r_phase[15]) begin
                    w_wave = -$signed({2'b00, r_sine});
                end else begin
                    w_wave = $signed({2'b00, r_sine});
                end
            end
        endcase
    end

    // Track value: bias plus amplitude times wave, Q.23
    logic signed [33:0] w_amp_prod;
    logic signed [34:0] w_track;
    assign w_amp_prod = $signed(i_cfg.amplitude) * w_wave;
    assign w_track    = $signed({{4{i_cfg.bias[15]}}, i_cfg.bias, 15'b0})
                      + $signed({w_amp_prod[33], w_amp_prod});

    // Weighted value, floor to Q16.16, saturated; zero while the clip is stopped
    logic signed [50:0] w_scaled;
    logic [35:0]        w_shr;
    logic [31:0]        w_value;
    assign w_scaled = $signed(i_cfg.weight) * r_track;
    assign w_shr    = w_scaled[50:15];

    always_comb begin
        if (!r_playing) begin
            w_value = '0;
        end else if (w_shr[35:31] != {5{w_shr[35]}}) begin
            w_value = w_shr[35] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            w_value = w_shr[31:0];
        end
    end

    // Clip state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_playing <= 1'b0;
            r_done    <= 1'b0;
        end else if (i_cmd.advance) begin
            r_time    <= n_time;
            r_playing <= n_playing;
            r_done    <= n_done;
        end
    end

    // Pipeline payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= t_op'(i_op);
            r_step <= i_time_step;
        end
        if (i_cmd.mul_step) begin
            r_delta <= w_step_prod[39:8];
        end
        if (i_cmd.phase) begin
            r_phase <= w_tprod[23:8] + i_cfg.phase_offset;
        end
        if (i_cmd.lookup) begin
            r_sine <= w_rom[w_idx];
        end
        if (i_cmd.track) begin
            r_track <= w_track;
        end
        if (i_cmd.load_out) begin
            r_out_value    <= w_value;
            r_out_playing  <= r_playing;
            r_out_finished <= r_done;
        end
    end

    assign o_value    = r_out_value;
    assign o_playing  = r_out_playing;
    assign o_finished = r_out_finished;

    `CLT_ASSERT(a_finish_clamps, i_clk, i_rst_n,
        i_cmd.advance |=> (!r_done || (!r_playing && (r_time == i_cfg.duration))),
        "finished clip not stopped at its duration")
    `CLT_ASSERT(a_restart_zero, i_clk, i_rst_n,
        (i_cmd.advance && (r_op == OP_RESTART)) |=> (r_playing && (r_time == '0) && !r_done),
        "restart did not rewind the clip")

endmodule

/* rtl/clip_lfo_track_unit.sv */
// Top level of the clip LFO track unit.
//
// Use: one animation clip driving one low-frequency-oscillator track.
// Input channel (i_in_valid / o_in_ready) carries i_op (tick or restart) and
// i_time_step (signed Q8.16 seconds). Output channel (o_out_valid /
// i_out_ready) returns one transaction per input: o_value (Q16.16, saturated),
// o_playing and o_finished.
// The controller takes an input only in idle and walks it through the steps
// MUL, ADV, PHASE, LOOK, TRACK and SCALE: four dependent multiplies
// (step*speed, time*frequency, amplitude*wave, weight*track) and the
// registered sine table read, one step per cycle unless held in SCALE. A
// waiting result sits in the output register, so the next input is taken while
// the receiver stalls; only when a second result is ready and the first is
// still held does the datapath hold in its last step. Reset (synchronous,
// active low) restores the register defaults, rewinds the clip to time zero
// and stops it; no result is pending afterward. Configuration writes take
// effect at once; the user makes them only while idle, unchecked by the block.
`timescale 1ns / 1ps

module clip_lfo_track_unit
    import clt_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [23:0] i_time_step,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_value,
    output logic        o_playing,
    output logic        o_finished,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg w_cfg;
    t_cmd w_cmd;

    clt_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    clt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    clt_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_op        (i_op),
        .i_time_step (i_time_step),
        .o_value     (o_value),
        .o_playing   (o_playing),
        .o_finished  (o_finished)
    );

endmodule
